// ----- sv/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// mexp_pkg
// shared widths and command type for the modular exponentiation block
// ----------------------------------------------------------------------------
package mexp_pkg;

	localparam int BASE_W = 63;
	localparam int EXP_FIELD_W = 63;
	localparam int MOD_FIELD_W = 32;
	localparam int RES_W = 32;
	// bit counter of the multiply-reduce unit, holds up to BASE_W
	localparam int CNT_W = 7;

	typedef struct packed {
		logic start;
		logic [CNT_W-1:0] nbits;
	} mm_cmd_t;

endpackage

// ----- sv/mexp_operand_if.sv -----
// ----------------------------------------------------------------------------
// mexp_operand_if
// operand channel: base, exponent and modulus with valid/ready
// ----------------------------------------------------------------------------
interface mexp_operand_if import mexp_pkg::*; ;
	logic valid;
	logic ready;
	logic [BASE_W-1:0] base_value;
	logic [EXP_FIELD_W-1:0] exponent_value;
	logic [MOD_FIELD_W-1:0] modulus_value;

	modport source (output valid, output base_value, output exponent_value,
		output modulus_value, input ready);
	modport sink (input valid, input base_value, input exponent_value,
		input modulus_value, output ready);
endinterface

// ----- sv/mexp_result_if.sv -----
// ----------------------------------------------------------------------------
// mexp_result_if
// result channel: power result with valid/ready
// ----------------------------------------------------------------------------
interface mexp_result_if import mexp_pkg::*; ;
	logic valid;
	logic ready;
	logic [RES_W-1:0] power_result;

	modport source (output valid, output power_result, input ready);
	modport sink (input valid, input power_result, output ready);
endinterface

// ----- sv/mexp_mulmod.sv -----
// ----------------------------------------------------------------------------
// mexp_mulmod
// bit-serial interleaved multiply-reduce: res = (x * y) mod m, one bit of y
// per cycle from the top of y, nbits bits per command
// ----------------------------------------------------------------------------
module mexp_mulmod import mexp_pkg::*; #(
	parameter int MOD_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  mm_cmd_t cmd,
	input  logic [MOD_WIDTH-1:0] x,
	input  logic [BASE_W-1:0] y,
	input  logic [MOD_WIDTH-1:0] m,
	output logic done,
	output logic [MOD_WIDTH-1:0] res
);

	localparam int T_W = MOD_WIDTH + 2;

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MOD_WIDTH-1:0] r_q;
	logic [BASE_W-1:0] y_q;

	logic [T_W-1:0] sum;
	logic [T_W-1:0] m_ext;
	logic [T_W-1:0] m2_ext;
	logic [MOD_WIDTH-1:0] r_nxt;

	// 2r + x stays below 3m, so at most one of m or 2m comes off
	always_comb begin
		m_ext = T_W'(m);
		m2_ext = {1'b0, m, 1'b0};
		sum = {1'b0, r_q, 1'b0} + (y_q[BASE_W-1] ? T_W'(x) : '0);
		if (sum >= m2_ext) begin
			r_nxt = MOD_WIDTH'(sum - m2_ext);
		end else if (sum >= m_ext) begin
			r_nxt = MOD_WIDTH'(sum - m_ext);
		end else begin
			r_nxt = MOD_WIDTH'(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && !cmd.start && (cnt_q == CNT_W'(1));
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q <= cmd.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			r_q <= '0;
			y_q <= y;
		end else if (busy_q) begin
			r_q <= r_nxt;
			y_q <= y_q << 1;
		end
	end

	assign done = done_q;
	assign res = r_q;

endmodule

// ----- sv/modular_exponentiation.sv -----
// ----------------------------------------------------------------------------
// modular_exponentiation
// base ^ exponent mod modulus by right-to-left binary square-and-multiply
// ----------------------------------------------------------------------------
// usage:
//   operands channel takes base_value, exponent_value and modulus_value; the
//   result channel returns power_result, one result per request.
//   only the low EXP_WIDTH exponent bits and low MOD_WIDTH modulus bits count.
//   a zero exponent gives 1 (also for modulus one), a zero modulus gives 0.
// operation:
//   one bit-serial multiply-reduce unit does all the work. each multiply has
//   a start step, takes one operand bit per cycle and ends in a finish step.
//   the base is first reduced over all BASE_W base bits, then each exponent
//   bit up to the highest set one costs one decision step plus a multiply
//   over MOD_WIDTH bits for a clear bit and two for a set bit (no square
//   after the top bit), and one finish step loads the result. the special
//   cases go straight from idle to the finish step.
// throughput:
//   one request at a time; operands.ready is high only while the sequencer
//   is idle. a finished result sits in an output register, so a new request
//   is taken while the previous result waits on a stalled receiver.
// reset:
//   arst_n clears the sequencer and the output valid; nothing else is kept.
module modular_exponentiation import mexp_pkg::*; #(
	parameter int MOD_WIDTH = 32,
	parameter int EXP_WIDTH = 63
) (
	input  logic clk,
	input  logic arst_n,
	mexp_operand_if.sink operands,
	mexp_result_if.source result
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RED,
		S_BIT,
		S_MUL,
		S_SQR,
		S_DONE
	} state_t;

	state_t state_q;
	logic start_q;
	logic [CNT_W-1:0] nbits_q;
	logic [BASE_W-1:0] base_q;
	logic [EXP_WIDTH-1:0] exp_q;
	logic [MOD_WIDTH-1:0] mod_q;
	logic [MOD_WIDTH-1:0] acc_q;
	logic [MOD_WIDTH-1:0] sq_q;
	logic [MOD_WIDTH-1:0] res_q;
	logic out_valid_q;
	logic [RES_W-1:0] out_data_q;

	logic [MOD_WIDTH-1:0] mod_in;
	logic [EXP_WIDTH-1:0] exp_in;
	logic [EXP_WIDTH-1:0] exp_rest;
	logic last_bit;
	logic [MOD_WIDTH-1:0] one_mod;
	logic [MOD_WIDTH-1:0] mm_x;
	logic [BASE_W-1:0] mm_y;
	mm_cmd_t mm_cmd;
	logic mm_done;
	logic [MOD_WIDTH-1:0] mm_res;
	logic start_nxt;

	assign mod_in = operands.modulus_value[MOD_WIDTH-1:0];
	assign exp_in = operands.exponent_value[EXP_WIDTH-1:0];
	assign exp_rest = exp_q >> 1;
	assign last_bit = (exp_rest == '0);
	assign one_mod = (mod_q == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);

	// base reduction runs as (1 mod m) * base over all base bits
	always_comb begin
		case (state_q)
			S_RED: begin
				mm_x = one_mod;
				mm_y = base_q;
			end
			S_MUL: begin
				mm_x = acc_q;
				mm_y = {sq_q, {(BASE_W - MOD_WIDTH){1'b0}}};
			end
			default: begin
				mm_x = sq_q;
				mm_y = {sq_q, {(BASE_W - MOD_WIDTH){1'b0}}};
			end
		endcase
	end

	// a multiply starts on a full request, on every bit decision and after a
	// multiply that still needs its square
	always_comb begin
		case (state_q)
			S_IDLE: begin
				start_nxt = operands.valid && (mod_in != '0) && (exp_in != '0);
			end
			S_BIT: begin
				start_nxt = 1'b1;
			end
			S_MUL: begin
				start_nxt = mm_done && !last_bit;
			end
			default: begin
				start_nxt = 1'b0;
			end
		endcase
	end

	assign mm_cmd = '{start: start_q, nbits: nbits_q};

	mexp_mulmod #(.MOD_WIDTH(MOD_WIDTH)) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mm_cmd),
		.x      (mm_x),
		.y      (mm_y),
		.m      (mod_q),
		.done   (mm_done),
		.res    (mm_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b0;
			nbits_q <= '0;
			base_q <= '0;
			exp_q <= '0;
			mod_q <= '0;
			acc_q <= '0;
			sq_q <= '0;
			res_q <= '0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			start_q <= start_nxt;
			if (state_q == S_DONE && (!out_valid_q || result.ready)) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (operands.valid) begin
						base_q <= operands.base_value;
						exp_q <= exp_in;
						mod_q <= mod_in;
						acc_q <= (mod_in == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
						if (mod_in == '0) begin
							res_q <= '0;
							state_q <= S_DONE;
						end else if (exp_in == '0) begin
							res_q <= MOD_WIDTH'(1);
							state_q <= S_DONE;
						end else begin
							nbits_q <= CNT_W'(BASE_W);
							state_q <= S_RED;
						end
					end
				end
				S_RED: begin
					if (mm_done) begin
						sq_q <= mm_res;
						state_q <= S_BIT;
					end
				end
				S_BIT: begin
					// exponent is never zero here, so a clear bit always squares
					nbits_q <= CNT_W'(MOD_WIDTH);
					state_q <= exp_q[0] ? S_MUL : S_SQR;
				end
				S_MUL: begin
					if (mm_done) begin
						acc_q <= mm_res;
						if (last_bit) begin
							res_q <= mm_res;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SQR;
						end
					end
				end
				S_SQR: begin
					if (mm_done) begin
						sq_q <= mm_res;
						exp_q <= exp_rest;
						state_q <= S_BIT;
					end
				end
				S_DONE: begin
					if (!out_valid_q || result.ready) begin
						out_data_q <= RES_W'(res_q);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign operands.ready = (state_q == S_IDLE);
	assign result.valid = out_valid_q;
	assign result.power_result = out_data_q;

endmodule

// ----- sv/mexp_checker.sv -----
// ----------------------------------------------------------------------------
// mexp_checker
// port-level checks of the modular exponentiation block, bound to the top
// ----------------------------------------------------------------------------
module mexp_checker import mexp_pkg::*; #(
	parameter int MOD_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	mexp_operand_if.sink operands,
	mexp_result_if.source result
);

	// a result waits until the receiver takes it
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid)
		else $error("result valid dropped while stalled");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> $stable(result.power_result))
		else $error("result changed while stalled");

	// one request at a time
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		operands.valid && operands.ready |=> !operands.ready)
		else $error("ready stayed high after a request");

	// a new result is loaded only from the finish step, where ready is low
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> !$past(operands.ready))
		else $error("result appeared without a finish step");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ((result.power_result >> MOD_WIDTH) == '0))
		else $error("result wider than the modulus");

endmodule

bind modular_exponentiation mexp_checker #(.MOD_WIDTH(MOD_WIDTH)) u_mexp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.operands (operands),
	.result   (result)
);
